// ===== rtl/cfe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the byte-wide CRC-32 step for the envelope checker.
// Used by every module under rtl; depends on nothing else.
package cfe_pkg;

	localparam logic [31:0] CRC_POLY = 32'hedb88320;
	localparam logic [31:0] CRC_INIT = 32'hffffffff;
	localparam int unsigned HDR_LEN = 40;
	localparam int unsigned CRC_COVER = 36;
	localparam logic [26:0] PAY_MAX = 27'h7ffffff;
	localparam logic [26:0] MAX_PAYLOAD_RESET = 27'h4000000;
	localparam logic [31:0] EXP_VERSION_RESET = 32'd1;

	localparam logic [7:0] MAGIC [8] = '{8'h41, 8'h4e, 8'h54, 8'h43, 8'h48, 8'h4b, 8'h50, 8'h00};

	localparam logic [0:0] CFG_MAX_PAYLOAD = 1'b0;
	localparam logic [0:0] CFG_EXP_VERSION = 1'b1;

	typedef enum logic [2:0] {
		ST_OK,
		ST_OVERSIZE,
		ST_TRUNCATED,
		ST_BAD_MAGIC,
		ST_BAD_VERSION,
		ST_BAD_SEQ_LEN,
		ST_BAD_CRC
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_last;
		logic       slot_tag;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] sequence_number;
		logic [63:0] saved_seconds;
		logic [26:0] payload_bytes;
		logic        slot_out;
	} result_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = c ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
		end
		return x;
	endfunction

	function automatic logic [63:0] put_lane(input logic [63:0] word, input logic [2:0] lane,
			input logic [7:0] b);
		logic [63:0] w;
		w = word;
		for (int i = 0; i < 8; i++) begin
			if (lane == 3'(i)) begin
				w[i*8 +: 8] = b;
			end
		end
		return w;
	endfunction

endpackage

// ===== rtl/cfe_in_reg.sv =====
`timescale 1ns / 1ps
// Input register of the envelope checker: holds one accepted item until the
// tracking stage takes it. Uses cfe_pkg for the item type.
module cfe_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cfe_pkg::item_t in_item,
	input  logic           advance,
	output logic           item_valid,
	output cfe_pkg::item_t item
);

	logic           valid_s1;
	cfe_pkg::item_t item_s1;

	assign in_ready   = !valid_s1 || advance;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/cfe_track.sv =====
`timescale 1ns / 1ps
// Per-file state of the envelope checker: byte counter, CRC-32, header capture
// and the final checks. Uses cfe_pkg for types, constants and the CRC step.
module cfe_track #(
	parameter int COUNT_BITS = 27
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  cfe_pkg::item_t   item,
	input  logic [26:0]      max_payload,
	input  logic [31:0]      expected_version,
	output logic             res_valid,
	output cfe_pkg::result_t res
);

	localparam int CMP_W = (COUNT_BITS > 27) ? COUNT_BITS : 27;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] HDR = COUNT_BITS'(cfe_pkg::HDR_LEN);
	localparam logic [COUNT_BITS-1:0] COVER = COUNT_BITS'(cfe_pkg::CRC_COVER);

	logic [COUNT_BITS-1:0] count_q, count_n, payload;
	logic [31:0]           crc_q, crc_n;
	logic                  magic_q, magic_n;
	logic [31:0]           version_q, version_n;
	logic [63:0]           seq_q, seq_n;
	logic [63:0]           secs_q, secs_n;
	logic [63:0]           len_q, len_n;
	logic [31:0]           stored_q, stored_n;
	logic                  slot_q, slot_n;
	logic                  started_q;
	logic [2:0]            lane;
	logic [CMP_W-1:0]      pay_w;
	cfe_pkg::status_t      status;

	always_comb begin
		count_n   = count_q;
		crc_n     = crc_q;
		magic_n   = magic_q;
		version_n = version_q;
		seq_n     = seq_q;
		secs_n    = secs_q;
		len_n     = len_q;
		stored_n  = stored_q;
		slot_n    = started_q ? slot_q : item.slot_tag;
		lane      = count_q[2:0];

		if (item.has_byte && count_q != CNT_MAX) begin
			if (count_q < COUNT_BITS'(8)) begin
				if (item.data_byte != cfe_pkg::MAGIC[lane]) begin
					magic_n = 1'b0;
				end
			end else if (count_q < COUNT_BITS'(12)) begin
				version_n = 32'(cfe_pkg::put_lane({32'h0, version_q}, {1'b0, lane[1:0]},
					item.data_byte));
			end else if (count_q < COUNT_BITS'(20)) begin
				seq_n = cfe_pkg::put_lane(seq_q, lane + 3'd4, item.data_byte);
			end else if (count_q < COUNT_BITS'(28)) begin
				secs_n = cfe_pkg::put_lane(secs_q, lane + 3'd4, item.data_byte);
			end else if (count_q < COVER) begin
				len_n = cfe_pkg::put_lane(len_q, lane + 3'd4, item.data_byte);
			end else if (count_q < HDR) begin
				stored_n = 32'(cfe_pkg::put_lane({32'h0, stored_q}, {1'b0, lane[1:0]},
					item.data_byte));
			end
			if (count_q < COVER || count_q >= HDR) begin
				crc_n = cfe_pkg::crc_byte(crc_q, item.data_byte);
			end
			count_n = count_q + COUNT_BITS'(1);
		end

		payload = (count_n >= HDR) ? count_n - HDR : '0;
		pay_w   = CMP_W'(payload);

		if (count_n == CNT_MAX || pay_w > CMP_W'(max_payload)) begin
			status = cfe_pkg::ST_OVERSIZE;
		end else if (count_n < HDR) begin
			status = cfe_pkg::ST_TRUNCATED;
		end else if (!magic_n) begin
			status = cfe_pkg::ST_BAD_MAGIC;
		end else if (version_n != expected_version) begin
			status = cfe_pkg::ST_BAD_VERSION;
		end else if (seq_n == 64'h0 || len_n != 64'(payload)) begin
			status = cfe_pkg::ST_BAD_SEQ_LEN;
		end else if (~crc_n != stored_n) begin
			status = cfe_pkg::ST_BAD_CRC;
		end else begin
			status = cfe_pkg::ST_OK;
		end

		res.status          = status;
		res.sequence_number = seq_n;
		res.saved_seconds   = secs_n;
		res.payload_bytes   = (pay_w > CMP_W'(cfe_pkg::PAY_MAX)) ? cfe_pkg::PAY_MAX : pay_w[26:0];
		res.slot_out        = slot_n;
	end

	assign res_valid = step && item.is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			crc_q     <= cfe_pkg::CRC_INIT;
			magic_q   <= 1'b1;
			version_q <= '0;
			seq_q     <= '0;
			secs_q    <= '0;
			len_q     <= '0;
			stored_q  <= '0;
			slot_q    <= 1'b0;
			started_q <= 1'b0;
		end else if (step) begin
			if (item.is_last) begin
				count_q   <= '0;
				crc_q     <= cfe_pkg::CRC_INIT;
				magic_q   <= 1'b1;
				version_q <= '0;
				seq_q     <= '0;
				secs_q    <= '0;
				len_q     <= '0;
				stored_q  <= '0;
				slot_q    <= 1'b0;
				started_q <= 1'b0;
			end else begin
				count_q   <= count_n;
				crc_q     <= crc_n;
				magic_q   <= magic_n;
				version_q <= version_n;
				seq_q     <= seq_n;
				secs_q    <= secs_n;
				len_q     <= len_n;
				stored_q  <= stored_n;
				slot_q    <= slot_n;
				started_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/cfe_out_reg.sv =====
`timescale 1ns / 1ps
// Result register of the envelope checker: holds one result until the
// downstream side takes it. Uses cfe_pkg for the result type.
module cfe_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  cfe_pkg::result_t res,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output cfe_pkg::result_t out_res
);

	logic             valid_q;
	cfe_pkg::result_t res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && res_valid) begin
			res_q <= res;
		end
	end

endmodule

// ===== rtl/crc_framed_envelope_checker.sv =====
`timescale 1ns / 1ps
// Checks checkpoint files streamed one byte per item: a 40-byte header with
// magic, version, sequence, seconds, length and CRC-32, then the payload. One item
// is taken every clock cycle while no item marked last waits on the result side.
// The last item of a file is held in the input register, while the byte-wide
// CRC-32 update, header capture and final checks feed the result register.
// Stalls on the result side hold only items marked last.
module crc_framed_envelope_checker #(
	parameter int COUNT_BITS = 27
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // data_byte
	input  logic         s_axis_tlast,   // is_last
	input  logic [1:0]   s_axis_tuser,   // has_byte, slot_tag
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata,   // status, sequence_number, saved_seconds,
	                                     // payload_bytes, zero fill
	output logic         m_axis_tuser,   // slot_out
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	logic [26:0]      max_payload_q;
	logic [31:0]      exp_version_q;
	cfe_pkg::item_t   in_item, item;
	cfe_pkg::result_t res, out_res;
	logic             item_valid, advance, out_free, res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= cfe_pkg::MAX_PAYLOAD_RESET;
			exp_version_q <= cfe_pkg::EXP_VERSION_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				cfe_pkg::CFG_MAX_PAYLOAD: max_payload_q <= cfg_data[26:0];
				cfe_pkg::CFG_EXP_VERSION: exp_version_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_item.data_byte = s_axis_tdata;
	assign in_item.has_byte  = s_axis_tuser[0];
	assign in_item.is_last   = s_axis_tlast;
	assign in_item.slot_tag  = s_axis_tuser[1];

	assign advance = item_valid && (!item.is_last || out_free);

	cfe_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_item    (in_item),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	cfe_track #(
		.COUNT_BITS (COUNT_BITS)
	) u_track (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.item             (item),
		.max_payload      (max_payload_q),
		.expected_version (exp_version_q),
		.res_valid        (res_valid),
		.res              (res)
	);

	cfe_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.free      (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {2'b00, out_res.payload_bytes, out_res.saved_seconds,
		out_res.sequence_number, out_res.status};
	assign m_axis_tuser = out_res.slot_out;

endmodule

// ===== rtl/cfe_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the envelope checker, attached to the top level by bind.
// Uses cfe_pkg for the status codes.
module cfe_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [159:0] m_axis_tdata
);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
	else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
	else $error("input stalled while the result side is free");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == cfe_pkg::ST_TRUNCATED
		|-> m_axis_tdata[157:131] == 27'h0)
	else $error("truncated file reports payload bytes");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == cfe_pkg::ST_OK
		|-> m_axis_tdata[66:3] != 64'h0)
	else $error("accepted file with zero sequence number");

endmodule

bind crc_framed_envelope_checker cfe_checker u_cfe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== test/crc_framed_envelope_checker_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for crc_framed_envelope_checker: streams checkpoint files byte by byte,
// predicts the result of every file and compares each field with the block's result stream.
// Depends on cfe_pkg and the top module under rtl.
module crc_framed_envelope_checker_tb;

	localparam logic [63:0] SIG_WORD = 64'h00504b4843544e41;
	localparam logic [26:0] COUNT_FULL = 27'h7ffffff;
	localparam int unsigned ERR_MAGIC = 1;
	localparam int unsigned ERR_VERSION = 2;
	localparam int unsigned ERR_SEQ = 4;
	localparam int unsigned ERR_LENGTH = 8;
	localparam int unsigned ERR_CRC = 16;
	localparam int unsigned ERR_TRUNC = 32;
	localparam int unsigned ERR_ALL = 63;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;
	logic         s_axis_tlast;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [159:0] m_axis_tdata;
	logic         m_axis_tuser;
	logic         cfg_we;
	logic [0:0]   cfg_index;
	logic [31:0]  cfg_data;

	crc_framed_envelope_checker #(
		.COUNT_BITS(27)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	cfe_pkg::item_t   byte_items[$];
	cfe_pkg::result_t expected_verdicts[$];
	logic [7:0]       file_image[$];
	cfe_pkg::item_t   in_flight;
	cfe_pkg::result_t want;
	int               failures;
	int               items_queued;
	int unsigned      send_idle_pct;
	int unsigned      recv_idle_pct;

	logic [26:0] max_pay_cfg;
	logic [31:0] version_cfg;

	logic [26:0] seen_count;
	logic [31:0] running_crc;
	logic        magic_ok;
	logic [31:0] ver_field;
	logic [63:0] seq_field;
	logic [63:0] secs_field;
	logic [63:0] len_field;
	logic [31:0] crc_field;
	logic        held_slot;
	logic        file_started;

	always #2 clk = ~clk;

	function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		r = acc ^ {24'h000000, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ cfe_pkg::CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function automatic cfe_pkg::item_t make_item(input logic [7:0] d, input logic has,
			input logic last);
		cfe_pkg::item_t it;
		it.data_byte = d;
		it.has_byte = has;
		it.is_last = last;
		it.slot_tag = 1'($urandom);
		return it;
	endfunction

	task automatic clear_file();
		seen_count = '0;
		running_crc = cfe_pkg::CRC_INIT;
		magic_ok = 1'b1;
		ver_field = '0;
		seq_field = '0;
		secs_field = '0;
		len_field = '0;
		crc_field = '0;
		held_slot = 1'b0;
		file_started = 1'b0;
	endtask

	task automatic absorb_item(input cfe_pkg::item_t it);
		int p;
		logic [26:0] payload;
		cfe_pkg::status_t verdict;
		cfe_pkg::result_t r;
		if (!file_started) begin
			held_slot = it.slot_tag;
			file_started = 1'b1;
		end
		if (it.has_byte && seen_count != COUNT_FULL) begin
			p = int'(seen_count);
			if (p < 8) begin
				if (it.data_byte != SIG_WORD[p*8 +: 8]) magic_ok = 1'b0;
			end else if (p < 12) begin
				ver_field[(p-8)*8 +: 8] = it.data_byte;
			end else if (p < 20) begin
				seq_field[(p-12)*8 +: 8] = it.data_byte;
			end else if (p < 28) begin
				secs_field[(p-20)*8 +: 8] = it.data_byte;
			end else if (p < 36) begin
				len_field[(p-28)*8 +: 8] = it.data_byte;
			end else if (p < 40) begin
				crc_field[(p-36)*8 +: 8] = it.data_byte;
			end
			if (p < 36 || p >= 40) running_crc = crc32_step(running_crc, it.data_byte);
			seen_count = seen_count + 27'd1;
		end
		if (it.is_last) begin
			payload = (seen_count >= 27'd40) ? seen_count - 27'd40 : 27'd0;
			if (seen_count == COUNT_FULL || payload > max_pay_cfg)
				verdict = cfe_pkg::ST_OVERSIZE;
			else if (seen_count < 27'd40) verdict = cfe_pkg::ST_TRUNCATED;
			else if (!magic_ok) verdict = cfe_pkg::ST_BAD_MAGIC;
			else if (ver_field != version_cfg) verdict = cfe_pkg::ST_BAD_VERSION;
			else if (seq_field == 64'd0 || len_field != 64'(payload))
				verdict = cfe_pkg::ST_BAD_SEQ_LEN;
			else if (~running_crc != crc_field) verdict = cfe_pkg::ST_BAD_CRC;
			else verdict = cfe_pkg::ST_OK;
			r.status = verdict;
			r.sequence_number = seq_field;
			r.saved_seconds = secs_field;
			r.payload_bytes = payload;
			r.slot_out = held_slot;
			expected_verdicts.insert(expected_verdicts.size(), r);
			clear_file();
		end
	endtask

	task automatic send_image();
		bit empty_end;
		int first;
		first = byte_items.size();
		empty_end = (file_image.size() == 0) || ($urandom_range(0, 3) == 0);
		foreach (file_image[i]) begin
			if ($urandom_range(0, 9) == 0)
				byte_items.insert(byte_items.size(), make_item(8'($urandom), 1'b0, 1'b0));
			byte_items.insert(byte_items.size(), make_item(file_image[i], 1'b1,
				!empty_end && (i == file_image.size() - 1)));
		end
		if (empty_end)
			byte_items.insert(byte_items.size(), make_item(8'($urandom), 1'b0, 1'b1));
		items_queued += byte_items.size() - first;
	endtask

	task automatic queue_file(input int unsigned errs, input int pay_len, input int cut);
		logic [63:0] seq;
		logic [63:0] secs;
		logic [63:0] len;
		logic [31:0] ver;
		logic [31:0] crc;
		logic [7:0] body[$];
		int k;
		int at;
		int keep;
		seq = {$urandom, $urandom};
		if (seq == 64'd0) seq = 64'd1;
		case ($urandom_range(0, 9))
			0: secs = '0;
			1: secs = '1;
			default: secs = {$urandom, $urandom};
		endcase
		ver = version_cfg;
		len = 64'(pay_len);
		if (errs & ERR_VERSION) ver = ver ^ ($urandom | 32'd1);
		if (errs & ERR_SEQ) seq = '0;
		if (errs & ERR_LENGTH) begin
			if ($urandom_range(0, 1)) len = len + 64'($urandom_range(1, 3));
			else len = len ^ {($urandom | 32'd1), 32'd0};
		end
		file_image.delete();
		for (k = 0; k < 8; k++) file_image.insert(file_image.size(), SIG_WORD[k*8 +: 8]);
		if (errs & ERR_MAGIC) begin
			at = $urandom_range(0, 7);
			file_image[at] = file_image[at] ^ 8'($urandom_range(1, 255));
		end
		for (k = 0; k < 4; k++) file_image.insert(file_image.size(), ver[k*8 +: 8]);
		for (k = 0; k < 8; k++) file_image.insert(file_image.size(), seq[k*8 +: 8]);
		for (k = 0; k < 8; k++) file_image.insert(file_image.size(), secs[k*8 +: 8]);
		for (k = 0; k < 8; k++) file_image.insert(file_image.size(), len[k*8 +: 8]);
		crc = cfe_pkg::CRC_INIT;
		foreach (file_image[i]) crc = crc32_step(crc, file_image[i]);
		for (k = 0; k < pay_len; k++) body.insert(body.size(), 8'($urandom));
		foreach (body[i]) crc = crc32_step(crc, body[i]);
		crc = ~crc;
		if (errs & ERR_CRC) begin
			if (pay_len > 0 && $urandom_range(0, 1)) begin
				at = $urandom_range(0, pay_len - 1);
				body[at] = body[at] ^ 8'($urandom_range(1, 255));
			end else begin
				crc = crc ^ (32'd1 << $urandom_range(0, 31));
			end
		end
		for (k = 0; k < 4; k++) file_image.insert(file_image.size(), crc[k*8 +: 8]);
		foreach (body[i]) file_image.insert(file_image.size(), body[i]);
		if (errs & ERR_TRUNC) begin
			keep = (cut >= 0) ? cut : $urandom_range(0, 39);
			while (file_image.size() > keep) void'(file_image.pop_back());
		end
		send_image();
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == cfe_pkg::CFG_MAX_PAYLOAD) max_pay_cfg = val[26:0];
		else version_cfg = val;
	endtask

	task automatic wait_drained();
		while (byte_items.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic check_field(input string what, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, exp_v, act_v);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) absorb_item(in_flight);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (byte_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_flight = byte_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= in_flight.data_byte;
					s_axis_tlast <= in_flight.is_last;
					s_axis_tuser <= {in_flight.slot_tag, in_flight.has_byte};
				end else begin
					s_axis_tvalid <= 1'b0;
					s_axis_tdata <= 8'($urandom);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual 0x%0h slot %0d",
						$time, m_axis_tdata, m_axis_tuser);
					failures++;
				end else begin
					want = expected_verdicts.pop_front();
					check_field("status", 64'(want.status), 64'(m_axis_tdata[2:0]));
					check_field("sequence_number", want.sequence_number, m_axis_tdata[66:3]);
					check_field("saved_seconds", want.saved_seconds, m_axis_tdata[130:67]);
					check_field("payload_bytes", 64'(want.payload_bytes),
						64'(m_axis_tdata[157:131]));
					check_field("slot_out", 64'(want.slot_out), 64'(m_axis_tuser));
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int r;
		int pay_len;
		int unsigned errs;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = cfe_pkg::CFG_MAX_PAYLOAD;
		cfg_data = '0;
		failures = 0;
		max_pay_cfg = cfe_pkg::MAX_PAYLOAD_RESET;
		version_cfg = cfe_pkg::EXP_VERSION_RESET;
		clear_file();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Empty file, a one-byte file, a file whose slot comes from an empty first item,
		// and a header cut off inside the sequence number.
		byte_items.insert(byte_items.size(), cfe_pkg::item_t'{8'h00, 1'b0, 1'b1, 1'b0});
		byte_items.insert(byte_items.size(), cfe_pkg::item_t'{8'hff, 1'b1, 1'b1, 1'b1});
		byte_items.insert(byte_items.size(), cfe_pkg::item_t'{8'h5a, 1'b0, 1'b0, 1'b1});
		byte_items.insert(byte_items.size(), cfe_pkg::item_t'{8'h41, 1'b1, 1'b0, 1'b0});
		byte_items.insert(byte_items.size(), cfe_pkg::item_t'{8'ha5, 1'b0, 1'b1, 1'b0});
		queue_file(ERR_TRUNC, 0, 14);

		for (int phase = 0; phase < 6; phase++) begin
			if (phase != 0) begin
				wait_drained();
				case (phase)
					1: begin
						write_reg(cfe_pkg::CFG_MAX_PAYLOAD, 32'd0);
						write_reg(cfe_pkg::CFG_EXP_VERSION, 32'd0);
					end
					2: begin
						write_reg(cfe_pkg::CFG_MAX_PAYLOAD, {5'($urandom), 27'd16});
						write_reg(cfe_pkg::CFG_EXP_VERSION, 32'hffffffff);
					end
					3: begin
						write_reg(cfe_pkg::CFG_MAX_PAYLOAD, 32'hffffffff);
						write_reg(cfe_pkg::CFG_EXP_VERSION, $urandom);
					end
					4: begin
						write_reg(cfe_pkg::CFG_MAX_PAYLOAD, 32'd8);
						write_reg(cfe_pkg::CFG_EXP_VERSION, 32'd1);
					end
					default: begin
						write_reg(cfe_pkg::CFG_MAX_PAYLOAD, 32'(cfe_pkg::MAX_PAYLOAD_RESET));
						write_reg(cfe_pkg::CFG_EXP_VERSION, $urandom);
					end
				endcase
				@(posedge clk);
				cfg_we <= 1'b0;
			end
			case (phase / 2)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 69;
				end
				1: begin
					send_idle_pct = 69;
					recv_idle_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			items_queued = 0;
			while (items_queued < 200) begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					file_image.delete();
					repeat ($urandom_range(0, 60))
						file_image.insert(file_image.size(), 8'($urandom));
					send_image();
				end else begin
					if (r < 45) errs = 0;
					else if (r < 85) errs = 1 << $urandom_range(0, 5);
					else errs = $urandom_range(1, ERR_ALL);
					if (max_pay_cfg <= 27'd120 && $urandom_range(0, 4) == 0)
						pay_len = int'(max_pay_cfg) + $urandom_range(0, 1);
					else if ($urandom_range(0, 99) < 85)
						pay_len = $urandom_range(0, 16);
					else
						pay_len = $urandom_range(17, 120);
					queue_file(errs, pay_len, -1);
				end
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
